FILE: rtl/core/pbd_pkg.sv
// pbd_pkg: shared types, constants and the symbol decode function for the
// pem base64 body decoder; no dependencies
package pbd_pkg;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [2:0] QUAD_LEN   = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_ENDED  = 3'b100
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // results caused by one input word
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic [1:0]      nres;
        logic            ended;
        logic            err;
        logic            eob;
    } pbd_group_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == CHAR_PLUS)
        begin
            s.value = 6'd62;
        end
        else if (c == CHAR_SLASH)
        begin
            s.value = 6'd63;
        end
        else
        begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: rtl/core/pbd_if.sv
// pbd_if: valid/ready channel interfaces for text input and decoded output
// depends on nothing

interface pbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface pbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       body_ended;
    logic       decode_error;
    logic       object_done;

    modport source (output valid, output out_byte, output has_byte, output last_of_run,
                    output body_ended, output decode_error, output object_done,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input last_of_run,
                    input body_ended, input decode_error, input object_done,
                    output ready);
endinterface

FILE: rtl/core/pem_base64_body_decoder_top.sv
// pem_base64_body_decoder_top: first result word is valid in the cycle after accept;
// one input word per cycle while output is not stalled; a word ending a quad gives
// up to three result words, one per handshake; input waits until the last is taken
// rst_n asynchronous active low: header phase, quad cleared, no result pending
// depends on pbd_pkg, pbd_if, pbd_decode, pbd_serializer
module pem_base64_body_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    pbd_in_if.sink        data_in,
    pbd_out_if.source     data_out
);

    pbd_pkg::pbd_group_t group;
    logic                can_load;
    logic                fire;

    assign data_in.ready = can_load;
    assign fire          = data_in.valid && can_load;

    pbd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .in_byte       (data_in.in_byte),
        .end_of_buffer (data_in.end_of_buffer),
        .group         (group)
    );

    pbd_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .group        (group),
        .can_load     (can_load),
        .valid        (data_out.valid),
        .ready        (data_out.ready),
        .out_byte     (data_out.out_byte),
        .has_byte     (data_out.has_byte),
        .last_of_run  (data_out.last_of_run),
        .body_ended   (data_out.body_ended),
        .decode_error (data_out.decode_error),
        .object_done  (data_out.object_done)
    );

endmodule

FILE: rtl/core/pbd_decode.sv
// pbd_decode: phase and quad state, decodes one text word per accepted cycle
// into a result group; depends on pbd_pkg
module pbd_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic                end_of_buffer,
    output pbd_pkg::pbd_group_t group
);

    pbd_pkg::phase_t  phase_reg, phase_next;
    logic [23:0]      acc_reg, acc_next;
    logic [2:0]       sym_reg, sym_next;
    logic [2:0]       pad_reg, pad_next;
    pbd_pkg::sextet_t sx;
    logic             emit;

    assign sx = pbd_pkg::sextet_of(in_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        sym_next     = sym_reg;
        pad_next     = pad_reg;
        emit         = 1'b0;
        group        = '0;
        unique case (phase_reg)
            pbd_pkg::PH_HEADER:
            begin
                if (in_byte < pbd_pkg::CHAR_SPACE)
                begin
                    phase_next = pbd_pkg::PH_BODY;
                end
            end
            pbd_pkg::PH_BODY:
            begin
                if (in_byte >= pbd_pkg::CHAR_SPACE && !in_byte[7])
                begin
                    if (in_byte == pbd_pkg::CHAR_DASH)
                    begin
                        group.err   = (sym_reg != 3'd0);
                        group.ended = 1'b1;
                    end
                    else if (in_byte == pbd_pkg::CHAR_PAD)
                    begin
                        acc_next = {acc_reg[17:0], 6'd0};
                        pad_next = pad_reg + 3'd1;
                        sym_next = sym_reg + 3'd1;
                    end
                    else if (sx.valid)
                    begin
                        acc_next = {acc_reg[17:0], sx.value};
                        sym_next = sym_reg + 3'd1;
                    end
                    else
                    begin
                        group.err   = 1'b1;
                        group.ended = 1'b1;
                    end
                    if (group.ended)
                    begin
                        phase_next = pbd_pkg::PH_ENDED;
                    end
                    else if (sym_next >= pbd_pkg::QUAD_LEN)
                    begin
                        emit         = 1'b1;
                        group.bytes  = {acc_next[7:0], acc_next[15:8], acc_next[23:16]};
                        if (pad_next == 3'd0)
                        begin
                            group.nbytes = 2'd3;
                        end
                        else if (pad_next == 3'd1)
                        begin
                            group.nbytes = 2'd2;
                        end
                        else
                        begin
                            group.nbytes = 2'd1;
                        end
                        acc_next = '0;
                        sym_next = '0;
                        pad_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (end_of_buffer)
        begin
            phase_next = pbd_pkg::PH_HEADER;
            acc_next   = '0;
            sym_next   = '0;
            pad_next   = '0;
        end
        group.eob = end_of_buffer;
        if (emit)
        begin
            group.nres = group.nbytes;
        end
        else if (group.ended || end_of_buffer)
        begin
            group.nres = 2'd1;
        end
        else
        begin
            group.nres = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pbd_pkg::PH_HEADER;
            acc_reg   <= '0;
            sym_reg   <= '0;
            pad_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            sym_reg   <= sym_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

FILE: rtl/core/pbd_serializer.sv
// pbd_serializer: result register holding one group, hands out one result
// word per output handshake; depends on pbd_pkg
module pbd_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  pbd_pkg::pbd_group_t group,
    output logic                can_load,
    output logic                valid,
    input  logic                ready,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output logic                last_of_run,
    output logic                body_ended,
    output logic                decode_error,
    output logic                object_done
);

    pbd_pkg::pbd_group_t grp_reg;
    logic                valid_reg, valid_next;
    logic [1:0]          idx_reg, idx_next;
    logic                take;

    assign valid        = valid_reg;
    assign has_byte     = idx_reg < grp_reg.nbytes;
    assign out_byte     = has_byte ? grp_reg.bytes[idx_reg] : 8'd0;
    assign last_of_run  = (idx_reg == grp_reg.nres - 2'd1);
    assign body_ended   = grp_reg.ended;
    assign decode_error = grp_reg.err;
    assign object_done  = grp_reg.eob;
    assign take         = valid_reg && ready;
    assign can_load     = !valid_reg || (take && last_of_run);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            if (last_of_run)
            begin
                valid_next = 1'b0;
                idx_next   = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load)
        begin
            valid_next = (group.nres != 2'd0);
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= group;
        end
    end

endmodule

FILE: rtl/core/pbd_checker.sv
// pbd_checker: port-level assertions for pem_base64_body_decoder_top
// bound to the top level; depends on nothing
module pbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_eob,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       has_byte,
    input logic       last_of_run,
    input logic       object_done
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte))
        else $error("stalled output word changed");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result register stalled");

    a_eob_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_eob |=> out_valid && object_done)
        else $error("end of buffer gave no result");

    a_inner_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> has_byte)
        else $error("non-final result without a byte");

endmodule

bind pem_base64_body_decoder_top pbd_checker u_pbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (data_in.valid),
    .in_ready    (data_in.ready),
    .in_eob      (data_in.end_of_buffer),
    .out_valid   (data_out.valid),
    .out_ready   (data_out.ready),
    .out_byte    (data_out.out_byte),
    .has_byte    (data_out.has_byte),
    .last_of_run (data_out.last_of_run),
    .object_done (data_out.object_done)
);

FILE: test/pem_base64_body_decoder_top_tb.sv
`timescale 1ns / 1ps
// pem_base64_body_decoder_top_tb: drives pem text words into the decoder and checks each
// decoded word against an in-bench decoder model held by a small scoreboard class
// depends on pbd_pkg, pbd_if and pem_base64_body_decoder_top
module pem_base64_body_decoder_top_tb;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       body_ended;
        logic       decode_error;
        logic       object_done;
    } decoded_word_t;

    class pem_decode_scoreboard;
        pbd_pkg::phase_t phase;
        logic [23:0]     acc;
        logic [2:0]      sym_count;
        logic [2:0]      pad_count;
        decoded_word_t   decoded_q[$];
        int              mismatches;

        function new();
            phase = pbd_pkg::PH_HEADER;
            acc = '0;
            sym_count = '0;
            pad_count = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function bit symbol_value(input logic [7:0] c, output logic [5:0] v);
            v = '0;
            if (c >= "A" && c <= "Z")
            begin
                v = 6'(c - "A");
                return 1'b1;
            end
            if (c >= "a" && c <= "z")
            begin
                v = 6'(c - "a" + 26);
                return 1'b1;
            end
            if (c >= "0" && c <= "9")
            begin
                v = 6'(c - "0" + 52);
                return 1'b1;
            end
            if (c == pbd_pkg::CHAR_PLUS)
            begin
                v = 6'd62;
                return 1'b1;
            end
            if (c == pbd_pkg::CHAR_SLASH)
            begin
                v = 6'd63;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_text_word(input logic [7:0] c, input logic eob);
            logic [7:0]    dec [3];
            logic [5:0]    v;
            int            n;
            int            nres;
            bit            ended;
            bit            err;
            decoded_word_t w;
            n = 0;
            ended = 1'b0;
            err = 1'b0;
            case (phase)
                pbd_pkg::PH_HEADER:
                begin
                    if (c < pbd_pkg::CHAR_SPACE)
                    begin
                        phase = pbd_pkg::PH_BODY;
                    end
                end
                pbd_pkg::PH_BODY:
                begin
                    if (c >= pbd_pkg::CHAR_SPACE && c < 8'h80)
                    begin
                        if (c == pbd_pkg::CHAR_DASH)
                        begin
                            err = (sym_count != 3'd0);
                            ended = 1'b1;
                        end
                        else if (c == pbd_pkg::CHAR_PAD)
                        begin
                            acc = {acc[17:0], 6'd0};
                            pad_count = pad_count + 3'd1;
                            sym_count = sym_count + 3'd1;
                        end
                        else if (symbol_value(c, v))
                        begin
                            acc = {acc[17:0], v};
                            sym_count = sym_count + 3'd1;
                        end
                        else
                        begin
                            err = 1'b1;
                            ended = 1'b1;
                        end
                        if (ended)
                        begin
                            phase = pbd_pkg::PH_ENDED;
                        end
                        else if (sym_count >= pbd_pkg::QUAD_LEN)
                        begin
                            dec[0] = acc[23:16];
                            dec[1] = acc[15:8];
                            dec[2] = acc[7:0];
                            n = (pad_count == 3'd0) ? 3 : (pad_count == 3'd1) ? 2 : 1;
                            acc = '0;
                            sym_count = '0;
                            pad_count = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (eob)
            begin
                phase = pbd_pkg::PH_HEADER;
                acc = '0;
                sym_count = '0;
                pad_count = '0;
            end
            nres = (n > 0) ? n : (ended || eob) ? 1 : 0;
            for (int k = 0; k < nres; k++)
            begin
                w.out_byte = (k < n) ? dec[k] : 8'h00;
                w.has_byte = (k < n);
                w.last_of_run = (k == nres - 1);
                w.body_ended = ended;
                w.decode_error = err;
                w.object_done = eob;
                decoded_q.push_back(w);
            end
        endfunction

        function string word_str(input decoded_word_t w);
            return $sformatf("byte %h has %b last %b ended %b err %b done %b", w.out_byte,
                             w.has_byte, w.last_of_run, w.body_ended, w.decode_error,
                             w.object_done);
        endfunction

        function void check_decoded_word(input decoded_word_t got);
            decoded_word_t want;
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t unexpected decoded word: %s", $realtime, word_str(got));
                end
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.last_of_run !== want.last_of_run || got.body_ended !== want.body_ended ||
                got.decode_error !== want.decode_error ||
                got.object_done !== want.object_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t decoded word mismatch", $realtime);
                    $display("    expected %s", word_str(want));
                    $display("    actual   %s", word_str(got));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pbd_in_if  text_if ();
    pbd_out_if dec_if ();

    pem_base64_body_decoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .data_in  (text_if),
        .data_out (dec_if)
    );

    pem_decode_scoreboard sb = new();

    int idle_pct;
    int stall_pct;
    bit hold_off;
    int counted_items;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        dec_if.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin : mon
        decoded_word_t got;
        if (rst_n && dec_if.valid === 1'b1 && dec_if.ready === 1'b1)
        begin
            got.out_byte = dec_if.out_byte;
            got.has_byte = dec_if.has_byte;
            got.last_of_run = dec_if.last_of_run;
            got.body_ended = dec_if.body_ended;
            got.decode_error = dec_if.decode_error;
            got.object_done = dec_if.object_done;
            sb.check_decoded_word(got);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic e);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(posedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.in_byte <= b;
        text_if.end_of_buffer <= e;
        @(posedge clk);
        while (!text_if.ready)
        begin
            @(posedge clk);
        end
        sb.note_text_word(b, e);
        counted_items++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], 1'b0);
        end
    endtask

    task automatic drain_decoded();
        text_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] random_symbol();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26)
        begin
            return 8'("A" + r);
        end
        if (r < 52)
        begin
            return 8'("a" + r - 26);
        end
        if (r < 62)
        begin
            return 8'("0" + r - 52);
        end
        return (r == 62) ? pbd_pkg::CHAR_PLUS : pbd_pkg::CHAR_SLASH;
    endfunction

    function automatic logic [7:0] bad_symbol();
        logic [7:0] c;
        logic [5:0] v;
        do
        begin
            c = 8'($urandom_range(32, 127));
        end
        while (sb.symbol_value(c, v) || c == pbd_pkg::CHAR_PAD || c == pbd_pkg::CHAR_DASH);
        return c;
    endfunction

    function automatic logic [7:0] skipped_byte();
        return $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
    endfunction

    task automatic send_random_object(input bit broken);
        int nq;
        int pads;
        int cut;
        int kind;
        int r;
        repeat ($urandom_range(0, 4))
        begin
            send_word(8'($urandom_range(32, 255)), 1'b0);
        end
        send_word(8'($urandom_range(0, 31)), 1'b0);
        nq = $urandom_range(1, 5);
        r = $urandom_range(0, 9);
        pads = (r < 5) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : $urandom_range(3, 4);
        cut = broken ? $urandom_range(0, nq * 4 - 1) : -1;
        kind = $urandom_range(0, 2);
        for (int i = 0; i < nq * 4; i++)
        begin
            if (i == cut)
            begin
                if (kind == 2)
                begin
                    send_word(random_symbol(), 1'b1);
                    return;
                end
                send_word((kind == 0) ? bad_symbol() : pbd_pkg::CHAR_DASH, 1'b0);
                break;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                send_word(skipped_byte(), 1'b0);
            end
            send_word((i >= nq * 4 - pads) ? pbd_pkg::CHAR_PAD : random_symbol(), 1'b0);
        end
        send_word(pbd_pkg::CHAR_DASH, 1'b0);
        repeat ($urandom_range(0, 4))
        begin
            send_word(8'($urandom_range(32, 255)), 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        int idle_tab [4];
        int stall_tab [4];
        int r;
        int guard;
        idle_tab = '{0, 61, 0, 7};
        stall_tab = '{0, 0, 61, 7};
        rst_n = 1'b0;
        idle_pct = 0;
        counted_items = 0;
        text_if.valid <= 1'b0;
        text_if.in_byte <= 8'h00;
        text_if.end_of_buffer <= 1'b0;
        hold_off <= 1'b0;
        stall_pct <= 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header line, then body with skipped bytes, pads and a dash mid quad
        send_word("A", 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_str("TWFu");
        send_word(8'h80, 1'b0);
        send_word(8'h1F, 1'b0);
        send_str("+/9=");
        send_str("z=A=");
        send_word("a", 1'b0);
        send_word(pbd_pkg::CHAR_DASH, 1'b0);
        send_word("Q", 1'b0);
        send_word("Q", 1'b1);
        // partial quad dropped at end of buffer
        send_word(8'h0A, 1'b0);
        send_str("AB");
        send_word("C", 1'b1);
        // space is not a symbol
        send_word(8'h0A, 1'b0);
        send_word(pbd_pkg::CHAR_SPACE, 1'b0);
        send_word(8'hFF, 1'b1);
        drain_decoded();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_tab[ph];
            stall_pct <= stall_tab[ph];
            if (ph == 0)
            begin
                hold_off <= 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            while (counted_items < (ph + 1) * 40)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    send_random_object(1'b0);
                end
                else if (r < 9)
                begin
                    send_random_object(1'b1);
                end
                else
                begin
                    repeat ($urandom_range(4, 12))
                    begin
                        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
                    end
                end
            end
            drain_decoded();
        end

        guard = 0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/pbd_pkg.sv
rtl/core/pbd_if.sv
rtl/core/pbd_decode.sv
rtl/core/pbd_serializer.sv
rtl/core/pem_base64_body_decoder_top.sv
rtl/core/pbd_checker.sv
test/pem_base64_body_decoder_top_tb.sv
